>>> src/ssym_pkg.sv
// Shared constants, codes and types of the scoped symbol table.
`default_nettype none
package ssym_pkg;

    // Table geometry
    localparam int SCOPE_DEPTH       = 16;
    localparam int ENTRIES_PER_SCOPE = 32;
    localparam int KEY_BITS          = 32;

    // Fixed field widths of the request and result ports
    localparam int NAME_KEY_W = 32;
    localparam int TYPE_W     = 4;
    localparam int STATUS_W   = 3;
    localparam int DEPTH_OUT_W = 5;

    // Derived widths
    localparam int KEY_W       = (KEY_BITS < NAME_KEY_W) ? KEY_BITS : NAME_KEY_W;
    localparam int DEPTH_W     = $clog2(SCOPE_DEPTH + 1);
    localparam int SCOPE_IDX_W = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
    localparam int FILL_W      = $clog2(ENTRIES_PER_SCOPE + 1);
    localparam int ENT_IDX_W   = (ENTRIES_PER_SCOPE > 1) ? $clog2(ENTRIES_PER_SCOPE) : 1;
    localparam int ADDR_W      = SCOPE_IDX_W + ENT_IDX_W;
    localparam int DATA_W      = KEY_W + TYPE_W;
    localparam int RAM_DEPTH   = 1 << ADDR_W;

    typedef enum logic [1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_ADD    = 2'd2,
        REQ_LOOKUP = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_NOSCOPE  = 3'd4
    } t_status;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              strobe;
        t_status           status;
        logic [TYPE_W-1:0] found;
    } t_result;

endpackage
`default_nettype wire

>>> src/scoped_symbol_table.sv
// Top level of the scoped symbol table: request port, sequencer and entry RAM.
//
//  Channel  Ports                                             Transfer when
//  -------  ------------------------------------------------  ------------------
//  request  start, busy, i_req_type, i_name_key, i_sym_type   start && !busy
//  result   o_strobe, o_status, o_found_type, o_depth         o_strobe (1 cycle)
//
// Push, pop, and add or lookup with no open scope answer in the cycle after the transfer.
// Add and lookup scan one entry per cycle via the RAM read port; a match ends the scan
// early, and an add to a full scope answers without reading an entry. A lookup miss scans
// every open scope. The result strobe comes in the first idle cycle.
// Synchronous active-low reset clears the scope count and fills, not the RAM.
// The receiver cannot stall: every result is shown for exactly one cycle.
`default_nettype none
module scoped_symbol_table
(
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           i_req_type,
    input  wire logic [ssym_pkg::NAME_KEY_W-1:0]      i_name_key,
    input  wire logic [ssym_pkg::TYPE_W-1:0]          i_sym_type,
    output logic                                      o_strobe,
    output logic [ssym_pkg::STATUS_W-1:0]             o_status,
    output logic [ssym_pkg::TYPE_W-1:0]               o_found_type,
    output logic [ssym_pkg::DEPTH_OUT_W-1:0]          o_depth
);
    import ssym_pkg::*;

    t_result            res;
    t_ram_req           ram_req;
    logic [DATA_W-1:0]  ram_rdata;
    logic [DEPTH_W-1:0] open_cnt;

    // Sequencer: owns the scope stack and drives the shared compare scan
    ssym_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_req   (t_req'(i_req_type)),
        .i_key   (i_name_key[KEY_W-1:0]),   // drop key bits above KEY_BITS
        .i_type  (i_sym_type),
        .o_busy  (busy),
        .o_res   (res),
        .o_depth (open_cnt),
        .o_ram   (ram_req),
        .i_rdata (ram_rdata)
    );

    // Entry store: {key, type} per slot, addressed {scope, entry}
    ssym_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    assign o_strobe     = res.strobe;
    assign o_status     = res.status;
    assign o_found_type = res.found;
    assign o_depth      = DEPTH_OUT_W'(open_cnt);

    // A result always comes with the sequencer back at rest
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

    // Leaving a scan always delivers its result
    a_scan_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("scan ended without a result");

    // Push and pop answer in the next cycle without a scan
    a_stack_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == REQ_PUSH || i_req_type == REQ_POP))
        |=> (o_strobe && !busy))
        else $error("push or pop did not answer in one cycle");

    // Only a successful lookup carries a type
    a_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |-> (o_found_type == '0))
        else $error("found type set on a failed request");

endmodule
`default_nettype wire

>>> src/ssym_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssym_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> src/ssym_seq.sv
// Request sequencer: scope stack state and the one-entry-per-cycle key scan.
`default_nettype none
module ssym_seq
(
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire ssym_pkg::t_req                    i_req,
    input  wire logic [ssym_pkg::KEY_W-1:0]        i_key,
    input  wire logic [ssym_pkg::TYPE_W-1:0]       i_type,
    output logic                                   o_busy,
    output ssym_pkg::t_result                      o_res,
    output logic [ssym_pkg::DEPTH_W-1:0]           o_depth,
    output ssym_pkg::t_ram_req                     o_ram,
    input  wire logic [ssym_pkg::DATA_W-1:0]       i_rdata
);
    import ssym_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state                  r_state, n_state;
    t_req                    r_req, n_req;
    logic [KEY_W-1:0]        r_key, n_key;
    logic [TYPE_W-1:0]       r_type, n_type;
    logic [SCOPE_IDX_W-1:0]  r_scope, n_scope;
    logic [FILL_W-1:0]       r_idx, n_idx;
    logic                    r_cmp_v, n_cmp_v;
    logic [DEPTH_W-1:0]      r_open, n_open;
    logic [FILL_W-1:0]       r_fill [SCOPE_DEPTH];
    logic [FILL_W-1:0]       n_fill [SCOPE_DEPTH];
    t_result                 r_res, n_res;

    logic [FILL_W-1:0]       cur_fill;
    logic                    key_hit;

    assign cur_fill = r_fill[r_scope];
    assign key_hit  = r_cmp_v && (i_rdata[DATA_W-1:TYPE_W] == r_key);

    always_comb begin
        n_state = r_state;
        n_req   = r_req;
        n_key   = r_key;
        n_type  = r_type;
        n_scope = r_scope;
        n_idx   = r_idx;
        n_cmp_v = r_cmp_v;
        n_open  = r_open;
        n_fill  = r_fill;
        n_res   = r_res;
        n_res.strobe = 1'b0;

        o_ram.we    = 1'b0;
        o_ram.waddr = {r_scope, cur_fill[ENT_IDX_W-1:0]};
        o_ram.wdata = {r_key, r_type};
        o_ram.raddr = {r_scope, r_idx[ENT_IDX_W-1:0]};

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req  = i_req;
                    n_key  = i_key;
                    n_type = i_type;
                    n_res.found = '0;
                    n_res.status = ST_OK;
                    case (i_req)
                        REQ_PUSH: begin
                            n_res.strobe = 1'b1;
                            if (r_open >= DEPTH_W'(SCOPE_DEPTH)) begin
                                n_res.status = ST_FULL;
                            end else begin
                                n_fill[SCOPE_IDX_W'(r_open)] = '0;
                                n_open = r_open + 1'b1;
                            end
                        end
                        REQ_POP: begin
                            n_res.strobe = 1'b1;
                            if (r_open == '0) begin
                                n_res.status = ST_NOSCOPE;
                            end else begin
                                n_open = r_open - 1'b1;
                            end
                        end
                        default: begin
                            if (r_open == '0) begin
                                n_res.strobe = 1'b1;
                                n_res.status = (i_req == REQ_ADD) ? ST_NOSCOPE : ST_NOTFOUND;
                            end else begin
                                n_scope = SCOPE_IDX_W'(r_open - 1'b1);
                                n_idx   = '0;
                                n_cmp_v = 1'b0;
                                n_state = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_req == REQ_ADD && cur_fill == FILL_W'(ENTRIES_PER_SCOPE)) begin
                    n_res.strobe = 1'b1;
                    n_res.status = ST_FULL;
                    n_state      = S_IDLE;
                end else if (key_hit) begin
                    n_res.strobe = 1'b1;
                    n_state      = S_IDLE;
                    if (r_req == REQ_ADD) begin
                        n_res.status = ST_DUP;
                    end else begin
                        n_res.status = ST_OK;
                        n_res.found  = i_rdata[TYPE_W-1:0];
                    end
                end else if (r_idx < cur_fill) begin
                    // advance: read this entry, compare it next cycle
                    n_idx   = r_idx + 1'b1;
                    n_cmp_v = 1'b1;
                end else if (r_req == REQ_LOOKUP && r_scope != '0) begin
                    n_scope = r_scope - 1'b1;
                    n_idx   = '0;
                    n_cmp_v = 1'b0;
                end else if (r_req == REQ_ADD) begin
                    o_ram.we        = 1'b1;
                    n_fill[r_scope] = cur_fill + 1'b1;
                    n_res.strobe    = 1'b1;
                    n_res.status    = ST_OK;
                    n_state         = S_IDLE;
                end else begin
                    n_res.strobe = 1'b1;
                    n_res.status = ST_NOTFOUND;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cmp_v      <= 1'b0;
            r_open       <= '0;
            r_res.strobe <= 1'b0;
            for (int i = 0; i < SCOPE_DEPTH; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_cmp_v      <= n_cmp_v;
            r_open       <= n_open;
            r_res.strobe <= n_res.strobe;
            r_fill       <= n_fill;
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_type       <= n_type;
        r_scope      <= n_scope;
        r_idx        <= n_idx;
        r_res.status <= n_res.status;
        r_res.found  <= n_res.found;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_res   = r_res;
    assign o_depth = r_open;

endmodule
`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench of the scoped symbol table: directed requests, then random traffic.
module tb_top;
    import ssym_pkg::*;

    // Run shape
    localparam int N_ITEMS      = 1150;   // no new episode starts once this many transfers are done
    localparam int QUIET_TAIL   = 150;    // last requests go back to back, no sender gaps
    localparam int STALL_LIMIT  = 4000;   // worst lookup scans 16 full scopes
    localparam int DRAIN_CYCLES = 40;     // hold after the last result to catch stray strobes
    localparam int POOL_SIZE    = 24;     // small key pool so hits, duplicates and shadows occur

    // Only the low KEY_W bits of a name key take part in storing and comparing
    localparam logic [NAME_KEY_W-1:0] KEY_MASK = {NAME_KEY_W{1'b1}} >> (NAME_KEY_W - KEY_W);

    typedef struct packed {
        t_status                  status;
        logic [TYPE_W-1:0]        found;
        logic [DEPTH_OUT_W-1:0]   depth;
    } sym_result_t;

    typedef struct packed {
        t_req                     req;
        logic [NAME_KEY_W-1:0]    key;
        logic [TYPE_W-1:0]        typ;
        logic                     typed;   // 1: use the written result, 0: use the predictor
        sym_result_t              result;
    } directed_row_t;

    localparam sym_result_t FROM_MODEL = '{ST_OK, 4'h0, 5'd0};

    // Directed walk: error codes on an empty table, extremes of key and type,
    // duplicates, shadowing across scopes, and visibility after pop and re-push.
    localparam directed_row_t DIRECTED_ROWS [25] = '{
        '{REQ_LOOKUP, 32'h0000_0000, 4'h0, 1'b1, '{ST_NOTFOUND, 4'h0, 5'd0}},
        '{REQ_POP,    32'hFFFF_FFFF, 4'hF, 1'b1, '{ST_NOSCOPE,  4'h0, 5'd0}},
        '{REQ_ADD,    32'hFFFF_FFFF, 4'hF, 1'b1, '{ST_NOSCOPE,  4'h0, 5'd0}},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 4'hF, 1'b1, '{ST_NOTFOUND, 4'h0, 5'd0}},
        '{REQ_PUSH,   32'hFFFF_FFFF, 4'hF, 1'b1, '{ST_OK,       4'h0, 5'd1}},
        '{REQ_ADD,    32'h0000_0000, 4'h0, 1'b1, '{ST_OK,       4'h0, 5'd1}},
        '{REQ_ADD,    32'hFFFF_FFFF, 4'hF, 1'b1, '{ST_OK,       4'h0, 5'd1}},
        '{REQ_ADD,    32'hFFFF_FFFF, 4'h3, 1'b1, '{ST_DUP,      4'h0, 5'd1}},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 4'h0, 1'b1, '{ST_OK,       4'hF, 5'd1}},
        '{REQ_LOOKUP, 32'h0000_0000, 4'hF, 1'b1, '{ST_OK,       4'h0, 5'd1}},
        '{REQ_LOOKUP, 32'h8000_0000, 4'h0, 1'b1, '{ST_NOTFOUND, 4'h0, 5'd1}},
        '{REQ_PUSH,   32'h0000_0000, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_ADD,    32'hFFFF_FFFF, 4'h5, 1'b0, FROM_MODEL},
        '{REQ_ADD,    32'hA5A5_A5A5, 4'hA, 1'b0, FROM_MODEL},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_LOOKUP, 32'h0000_0000, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_LOOKUP, 32'hA5A5_A5A5, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_POP,    32'h0000_0000, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_LOOKUP, 32'hFFFF_FFFF, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_LOOKUP, 32'hA5A5_A5A5, 4'h0, 1'b0, FROM_MODEL},
        '{REQ_POP,    32'h0000_0000, 4'h0, 1'b1, '{ST_OK,       4'h0, 5'd0}},
        '{REQ_LOOKUP, 32'h0000_0000, 4'h0, 1'b1, '{ST_NOTFOUND, 4'h0, 5'd0}},
        '{REQ_PUSH,   32'h0000_0000, 4'h0, 1'b1, '{ST_OK,       4'h0, 5'd1}},
        '{REQ_LOOKUP, 32'h0000_0000, 4'h0, 1'b1, '{ST_NOTFOUND, 4'h0, 5'd1}},
        '{REQ_POP,    32'h0000_0000, 4'h0, 1'b1, '{ST_OK,       4'h0, 5'd0}}
    };

    // Block ports; every input holds a known value from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    logic [1:0]                i_req_type = '0;
    logic [NAME_KEY_W-1:0]     i_name_key = '0;
    logic [TYPE_W-1:0]         i_sym_type = '0;
    logic                      o_strobe;
    logic [STATUS_W-1:0]       o_status;
    logic [TYPE_W-1:0]         o_found_type;
    logic [DEPTH_OUT_W-1:0]    o_depth;

    // Shadow copy of the table contents that the predictor keeps
    logic [NAME_KEY_W-1:0]     key_store  [SCOPE_DEPTH][ENTRIES_PER_SCOPE];
    logic [TYPE_W-1:0]         type_store [SCOPE_DEPTH][ENTRIES_PER_SCOPE];
    int                        scope_fill [SCOPE_DEPTH];
    int                        open_scopes = 0;

    sym_result_t               pending_results [$];   // oldest request first
    sym_result_t               oldest_result;
    logic [NAME_KEY_W-1:0]     name_pool [POOL_SIZE];
    int                        items_sent = 0;
    int                        quiet_cycles = 0;
    bit                        mismatch_seen = 1'b0;

    scoped_symbol_table DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_name_key   (i_name_key),
        .i_sym_type   (i_sym_type),
        .o_strobe     (o_strobe),
        .o_status     (o_status),
        .o_found_type (o_found_type),
        .o_depth      (o_depth)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Search one scope of the shadow table; first match wins.
    function automatic bit scope_holds(int scope, logic [NAME_KEY_W-1:0] key,
                                       output logic [TYPE_W-1:0] hit_type);
        hit_type = '0;
        for (int i = 0; i < scope_fill[scope]; i++) begin
            if (key_store[scope][i] == key) begin
                hit_type = type_store[scope][i];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Apply one request to the shadow table and return the result it must produce.
    function automatic sym_result_t apply_request(t_req req, logic [NAME_KEY_W-1:0] raw_key,
                                                  logic [TYPE_W-1:0] typ);
        sym_result_t           res;
        logic [NAME_KEY_W-1:0] key;
        logic [TYPE_W-1:0]     hit_type;
        int                    s;
        key        = raw_key & KEY_MASK;
        res.status = ST_OK;
        res.found  = '0;
        case (req)
            REQ_PUSH: begin
                if (open_scopes >= SCOPE_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    scope_fill[open_scopes] = 0;
                    open_scopes++;
                end
            end
            REQ_POP: begin
                if (open_scopes == 0)
                    res.status = ST_NOSCOPE;
                else
                    open_scopes--;
            end
            REQ_ADD: begin
                s = open_scopes - 1;
                if (open_scopes == 0) begin
                    res.status = ST_NOSCOPE;
                end else if (scope_fill[s] >= ENTRIES_PER_SCOPE) begin
                    // a full scope reports full even when the name is already there
                    res.status = ST_FULL;
                end else if (scope_holds(s, key, hit_type)) begin
                    res.status = ST_DUP;
                end else begin
                    key_store[s][scope_fill[s]]  = key;
                    type_store[s][scope_fill[s]] = typ;
                    scope_fill[s]++;
                end
            end
            default: begin
                // lookup: innermost scope first, so shadowing names win
                res.status = ST_NOTFOUND;
                for (s = open_scopes - 1; s >= 0; s--) begin
                    if (scope_holds(s, key, hit_type)) begin
                        res.status = ST_OK;
                        res.found  = hit_type;
                        break;
                    end
                end
            end
        endcase
        res.depth = DEPTH_OUT_W'(open_scopes);
        return res;
    endfunction

    // Mostly a pooled key, so names recur; now and then a fresh random one.
    function automatic logic [NAME_KEY_W-1:0] pick_key();
        if ($urandom_range(0, 4) == 0)
            return NAME_KEY_W'($urandom);
        return name_pool[$urandom_range(0, POOL_SIZE - 1)];
    endfunction

    // Present one request and hold it until the transfer. An optional sender gap
    // comes first: drop start and scramble the fields meanwhile, since the block
    // must ignore them. Gaps stop for the last stretch of the run.
    task automatic send_request(t_req req, logic [NAME_KEY_W-1:0] key, logic [TYPE_W-1:0] typ,
                                logic typed, sym_result_t written);
        sym_result_t predicted;
        int          gap;
        gap = 0;
        if (items_sent < N_ITEMS - QUIET_TAIL && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        repeat (gap) begin
            @(negedge i_clk);
            start      <= 1'b0;
            i_req_type <= 2'($urandom);
            i_name_key <= NAME_KEY_W'($urandom);
            i_sym_type <= TYPE_W'($urandom);
        end
        @(negedge i_clk);
        start      <= 1'b1;
        i_req_type <= req;
        i_name_key <= key;
        i_sym_type <= typ;
        // busy read right after the edge is its value before the edge
        do @(posedge i_clk); while (busy);
        predicted = apply_request(req, key, typ);
        pending_results.push_back(typed ? written : predicted);
        items_sent++;
    endtask

    // Result checker and watchdog. Results cannot be held off, so compare every
    // strobe against the oldest waiting expectation. The watchdog counts cycles
    // with neither a request transfer nor a result.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                if (pending_results.size() == 0) begin
                    $error("result with no request waiting: status %0d depth %0d",
                           o_status, o_depth);
                    mismatch_seen = 1'b1;
                end else begin
                    oldest_result = pending_results.pop_front();
                    if (o_status !== oldest_result.status) begin
                        $error("status: expected %0d, got %0d", oldest_result.status, o_status);
                        mismatch_seen = 1'b1;
                    end
                    if (o_found_type !== oldest_result.found) begin
                        $error("found_type: expected %0d, got %0d",
                               oldest_result.found, o_found_type);
                        mismatch_seen = 1'b1;
                    end
                    if (o_depth !== oldest_result.depth) begin
                        $error("depth: expected %0d, got %0d", oldest_result.depth, o_depth);
                        mismatch_seen = 1'b1;
                    end
                end
            end
            if ((start && !busy) || o_strobe)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int   episode;
        int   pick;
        t_req kind;
        // Key pool holds the extremes and a few single-bit keys among random ones
        name_pool[0] = '0;
        name_pool[1] = '1;
        name_pool[2] = 32'h8000_0000;
        name_pool[3] = 32'h0000_0001;
        for (int i = 4; i < POOL_SIZE; i++)
            name_pool[i] = NAME_KEY_W'($urandom);

        // Hold reset, then release it away from the rising edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED_ROWS[r])
            send_request(DIRECTED_ROWS[r].req, DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].typ,
                         DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].result);

        // Random traffic in episodes: push and pop bursts reach a full and an empty
        // stack, fill runs overflow a scope, mixed runs hit, miss and shadow names,
        // and a little noise sends requests with every field random.
        while (items_sent < N_ITEMS) begin
            episode = $urandom_range(0, 99);
            if (episode < 10) begin
                repeat ($urandom_range(1, SCOPE_DEPTH + 1))
                    send_request(REQ_PUSH, NAME_KEY_W'($urandom), TYPE_W'($urandom),
                                 1'b0, FROM_MODEL);
            end else if (episode < 18) begin
                repeat ($urandom_range(1, SCOPE_DEPTH + 1))
                    send_request(REQ_POP, NAME_KEY_W'($urandom), TYPE_W'($urandom),
                                 1'b0, FROM_MODEL);
            end else if (episode < 26) begin
                if (open_scopes == 0)
                    send_request(REQ_PUSH, NAME_KEY_W'($urandom), TYPE_W'($urandom),
                                 1'b0, FROM_MODEL);
                repeat (ENTRIES_PER_SCOPE + 2)
                    send_request(REQ_ADD,
                                 ($urandom_range(0, 7) == 0) ? pick_key()
                                                             : NAME_KEY_W'($urandom),
                                 TYPE_W'($urandom), 1'b0, FROM_MODEL);
            end else if (episode < 30) begin
                repeat (4)
                    send_request(t_req'($urandom_range(0, 3)), NAME_KEY_W'($urandom),
                                 TYPE_W'($urandom), 1'b0, FROM_MODEL);
            end else begin
                repeat (8) begin
                    pick = $urandom_range(0, 99);
                    kind = (pick < 15) ? REQ_PUSH :
                           (pick < 27) ? REQ_POP  :
                           (pick < 65) ? REQ_ADD  : REQ_LOOKUP;
                    send_request(kind, pick_key(), TYPE_W'($urandom), 1'b0, FROM_MODEL);
                end
            end
        end

        // Drop start so the last request is not taken twice, then drain
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (!mismatch_seen)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
